// File: hw/rtl/pfbtw_pkg.sv
// shared types, constants and font table for the paged frame buffer text writer
package pfbtw_pkg;

  localparam int unsigned PAGES_DEF   = 8;
  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned GLYPH_W     = 5;
  localparam int unsigned FIRST_CHAR  = 32;
  localparam int unsigned LAST_CHAR   = 126;

  typedef enum logic [3:0] {
    OP_WRITE   = 4'd0,
    OP_APPEND  = 4'd1,
    OP_PIXEL   = 4'd2,
    OP_CHAR    = 4'd3,
    OP_GOTO    = 4'd4,
    OP_CLR_PG  = 4'd5,
    OP_INV_PG  = 4'd6,
    OP_READ    = 4'd7,
    OP_CLR_ALL = 4'd8
  } opcode_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] data_byte;
    logic       invert_flag;
    logic [6:0] column;
    logic [5:0] pixel_row;
    logic [6:0] char_code;
    logic [2:0] page;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] cursor_page;
    logic [6:0] cursor_column;
    logic       bad_char;
  } out_item_t;

  // datapath step selected by the controller
  typedef enum logic [2:0] {
    DP_NONE  = 3'd0,
    DP_LOAD  = 3'd1,  // latch item, set cursor per opcode
    DP_RDREQ = 3'd2,  // issue memory read at cursor or read address
    DP_WRITE = 3'd3,  // write computed byte at cursor, advance
    DP_CLEAR = 3'd4,  // clearing sweep step
    DP_DONE  = 3'd5   // build result
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       last_byte;   // glyph or page walk at its final byte; always set for other opcodes
    logic       sweep_last;  // clearing sweep at final entry
  } dp_stat_t;

  function automatic logic [7:0] glyph_col(input logic [6:0] idx, input logic [2:0] c);
    logic [39:0] g;
    unique case (idx)
      7'd0: g = 40'h0000000000; 7'd1: g = 40'h00005F0000; 7'd2: g = 40'h0007000700;
      7'd3: g = 40'h147F147F14; 7'd4: g = 40'h242A7F2A12; 7'd5: g = 40'h2313086462;
      7'd6: g = 40'h3649552250; 7'd7: g = 40'h0005030000; 7'd8: g = 40'h001C224100;
      7'd9: g = 40'h0041221C00; 7'd10: g = 40'h082A1C2A08; 7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402; 7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31; 7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539; 7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E; 7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000; 7'd28: g = 40'h0008142241; 7'd29: g = 40'h1414141414;
      7'd30: g = 40'h4122140800; 7'd31: g = 40'h0201510906; 7'd32: g = 40'h324979413E;
      7'd33: g = 40'h7E1111117E; 7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C; 7'd37: g = 40'h7F49494941; 7'd38: g = 40'h7F09090101;
      7'd39: g = 40'h3E41415132; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241; 7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F0204027F; 7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E; 7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h4649494931; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h7F2018207F; 7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0304780403; 7'd58: g = 40'h6151494543; 7'd59: g = 40'h00007F4141;
      7'd60: g = 40'h0204081020; 7'd61: g = 40'h41417F0000; 7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040; 7'd64: g = 40'h0001020400; 7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420; 7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418; 7'd70: g = 40'h087E090102; 7'd71: g = 40'h081454543C;
      7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000; 7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h007F102844; 7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438; 7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C; 7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C; 7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C; 7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364100; 7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0041360800; 7'd94: g = 40'h0201030201;
      default: g = 40'h0000000000;
    endcase
    unique case (c)
      3'd0: glyph_col = g[39:32];
      3'd1: glyph_col = g[31:24];
      3'd2: glyph_col = g[23:16];
      3'd3: glyph_col = g[15:8];
      3'd4: glyph_col = g[7:0];
      default: glyph_col = 8'h00;
    endcase
  endfunction

endpackage

// File: hw/rtl/pfbtw_ctrl.sv
// controller state machine sequencing the frame buffer datapath
module pfbtw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pfbtw_pkg::dp_stat_t stat,
  output pfbtw_pkg::dp_cmd_t  cmd
);
  import pfbtw_pkg::*;

  typedef enum logic [6:0] {
    S_SWEEP = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DISP  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WR    = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NONE;
    unique case (state_r)
      S_SWEEP: begin
        cmd.op = DP_CLEAR;
        if (stat.sweep_last) state_nxt = S_FIN;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority case (stat.opcode)
          OP_WRITE, OP_CHAR, OP_CLR_PG: state_nxt = S_WR;
          OP_APPEND, OP_PIXEL, OP_INV_PG, OP_READ: begin
            cmd.op    = DP_RDREQ;
            state_nxt = S_RD;
          end
          OP_CLR_ALL: state_nxt = S_SWEEP;
          default: state_nxt = S_FIN;
        endcase
      end
      S_RD: begin
        state_nxt = (stat.opcode == OP_READ) ? S_FIN : S_WR;
      end
      S_WR: begin
        cmd.op = DP_WRITE;
        if (stat.last_byte) state_nxt = S_FIN;
        else if (stat.opcode == OP_CHAR || stat.opcode == OP_CLR_PG) state_nxt = S_WR;
        else state_nxt = S_DISP;
      end
      S_FIN: begin
        cmd.op    = DP_DONE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_SWEEP;
    else        state_r <= state_nxt;
  end
endmodule

// File: hw/rtl/pfbtw_dp.sv
// datapath: frame memory, cursor, glyph and page walk counters, result register
module pfbtw_dp #(
  parameter int unsigned PAGES   = pfbtw_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS = pfbtw_pkg::COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfbtw_pkg::in_item_t   in_item,
  input  pfbtw_pkg::dp_cmd_t    cmd,
  output pfbtw_pkg::dp_stat_t   stat,
  output pfbtw_pkg::out_item_t  out_item
);
  import pfbtw_pkg::*;

  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned DEPTH = PAGES * COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = CW + 1;

  logic [7:0] mem [DEPTH];

  in_item_t     item_r;
  logic [PW-1:0] pg_r, pg_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;      // bytes written in current walk
  logic [AW-1:0] swp_r;
  out_item_t     out_r;

  logic [AW-1:0] cur_addr, rd_addr, wr_addr;
  logic [7:0]    wbyte, gcol, pix;
  logic [6:0]    gidx;
  logic          bad;
  logic [PW-1:0] ld_pg;
  logic [CW-1:0] ld_col;
  logic          wr_en;
  logic [PW+CW-1:0] cur_cat;
  logic [7:0]    dout_r;

  assign cur_cat  = {pg_r, col_r};
  assign cur_addr = AW'(pg_r * COLUMNS + col_r);
  assign rd_addr  = (item_r.opcode == OP_READ)
                  ? AW'((PW'(item_r.page % PAGES)) * COLUMNS + CW'(item_r.column % COLUMNS))
                  : cur_addr;

  assign bad  = (item_r.char_code < 7'(FIRST_CHAR)) || (item_r.char_code > 7'(LAST_CHAR));
  assign gidx = bad ? 7'd0 : item_r.char_code - 7'(FIRST_CHAR);
  assign gcol = glyph_col(gidx, cnt_r[2:0]);
  assign pix  = 8'(1) << item_r.pixel_row[2:0];

  always_comb begin
    wbyte = 8'h00;
    unique case (item_r.opcode)
      OP_WRITE:  wbyte = item_r.data_byte;
      OP_APPEND: wbyte = item_r.invert_flag ? (dout_r ^ item_r.data_byte)
                                            : (dout_r | item_r.data_byte);
      OP_PIXEL:  wbyte = item_r.invert_flag ? (dout_r ^ pix) : (dout_r | pix);
      OP_CHAR:   wbyte = item_r.invert_flag ? ~gcol : gcol;
      OP_INV_PG: wbyte = ~dout_r;
      default:   wbyte = 8'h00;
    endcase
  end

  // cursor load value per opcode
  always_comb begin
    ld_pg  = pg_r;
    ld_col = col_r;
    unique case (in_item.opcode)
      OP_PIXEL: begin
        ld_pg  = PW'(32'(in_item.pixel_row[5:3]) % PAGES);
        ld_col = CW'(32'(in_item.column) % COLUMNS);
      end
      OP_GOTO: begin
        ld_pg  = PW'(32'(in_item.page) % PAGES);
        ld_col = CW'(32'(in_item.column) % COLUMNS);
      end
      OP_CLR_PG, OP_INV_PG: begin
        ld_pg  = PW'(32'(in_item.page) % PAGES);
        ld_col = '0;
      end
      OP_CLR_ALL: begin
        ld_pg  = '0;
        ld_col = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    pg_nxt  = pg_r;
    col_nxt = col_r;
    cnt_nxt = cnt_r;
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    unique case (cmd.op)
      DP_LOAD: begin
        pg_nxt  = ld_pg;
        col_nxt = ld_col;
        cnt_nxt = '0;
      end
      DP_WRITE: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (32'(col_r) + 1 < COLUMNS) col_nxt = col_r + 1'b1;
        else begin
          col_nxt = '0;
          pg_nxt  = (32'(pg_r) + 1 < PAGES) ? pg_r + 1'b1 : '0;
        end
      end
      DP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = swp_r;
      end
      default: ;
    endcase
  end

  assign stat.opcode     = item_r.opcode;
  assign stat.sweep_last = (32'(swp_r) == DEPTH - 1);
  always_comb begin
    unique case (item_r.opcode)
      OP_CHAR:              stat.last_byte = (32'(cnt_r) == GLYPH_W - 1);
      OP_CLR_PG, OP_INV_PG: stat.last_byte = (32'(cnt_r) == COLUMNS - 1);
      default:              stat.last_byte = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= (cmd.op == DP_CLEAR) ? 8'h00 : wbyte;
    if (cmd.op == DP_RDREQ) dout_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r  <= '0;
      col_r <= '0;
      cnt_r <= '0;
      swp_r <= '0;
      item_r.opcode <= 4'hF;
    end else begin
      pg_r  <= pg_nxt;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.op == DP_CLEAR) swp_r <= stat.sweep_last ? '0 : swp_r + 1'b1;
      if (cmd.op == DP_LOAD) item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_DONE) begin
      out_r.read_data     <= (item_r.opcode == OP_READ) ? dout_r : 8'h00;
      out_r.cursor_page   <= 3'(cur_cat[PW+CW-1:CW]);
      out_r.cursor_column <= 7'(col_r);
      out_r.bad_char      <= (item_r.opcode == OP_CHAR) && bad;
    end
  end

  assign out_item = out_r;
endmodule

// File: hw/rtl/paged_framebuffer_text_writer_core.sv
// top level: paged frame buffer text writer with 5x7 glyph generator
// sequence after accept: goto and unused opcodes go straight to finish; write and
//   read one byte, append/pixel modify one byte, glyph 5 bytes, clear page a page,
//   invert page (read, modify, write per byte), clear all (one byte per cycle)
// throughput: one item at a time, next item taken after the result is taken
// reset: synchronous active-low rst_n zeroes the cursor and starts a clearing
//   pass over all PAGES*COLUMNS bytes (1024 by default); its result is dropped and
//   the first item is taken after the finish and result states that follow the pass
module paged_framebuffer_text_writer_core #(
  parameter int unsigned PAGES   = pfbtw_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS = pfbtw_pkg::COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pfbtw_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pfbtw_pkg::out_item_t  out_data
);
  import pfbtw_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      ov;
  logic      boot_r;   // set until the reset clearing pass has finished

  // during the boot pass the result state is left at once, no one takes it
  pfbtw_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .out_valid(ov), .out_stall(out_stall && !boot_r),
    .stat, .cmd
  );

  pfbtw_dp #(.PAGES(PAGES), .COLUMNS(COLUMNS)) u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .stat, .out_item(out_data)
  );

  // the reset sweep ends in the result state; drop that result silently
  always_ff @(posedge clk) begin
    if (!rst_n)   boot_r <= 1'b1;
    else if (ov)  boot_r <= 1'b0;
  end

  assign out_valid = ov && !boot_r;
endmodule

// File: hw/rtl/pfbtw_checker.sv
// port-level checker for the frame buffer text writer, bound to the top level
module pfbtw_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input pfbtw_pkg::out_item_t out_data
);
  import pfbtw_pkg::*;

  // one item in flight: no accept while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // accepted item never yields a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");

  // bad_char only together with zero read data
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_char |-> out_data.read_data == 8'h00)
    else $error("bad_char with read data");
endmodule

bind paged_framebuffer_text_writer_core pfbtw_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

// File: dv/testbench.sv
// self-checking testbench for the paged frame buffer text writer core
module testbench;
  import pfbtw_pkg::*;

  localparam int NPAGE = 8;
  localparam int NCOL = 128;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  paged_framebuffer_text_writer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the frame and cursor
  logic [7:0] shadow_frame [NPAGE*NCOL];
  logic [2:0] shadow_page;
  logic [6:0] shadow_col;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int error_count = 0;
  bit stimulus_done = 1'b0;
  bit quiet_tail = 1'b0;
  int hold_off = 0;

  // font columns, 5 per glyph, first column in the top byte
  logic [39:0] font [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0201030201
  };

  function automatic int frame_index(logic [2:0] pg, logic [6:0] col);
    return int'(pg) * NCOL + int'(col);
  endfunction

  // store a byte at the cursor and step the cursor forward
  function automatic void store_and_advance(logic [7:0] value);
    shadow_frame[frame_index(shadow_page, shadow_col)] = value;
    if (shadow_col == 7'(NCOL - 1)) begin
      shadow_col = '0;
      shadow_page = shadow_page + 3'd1;
    end else begin
      shadow_col = shadow_col + 7'd1;
    end
  endfunction

  function automatic void combine_at_cursor(logic [7:0] value, logic use_xor);
    logic [7:0] old;
    old = shadow_frame[frame_index(shadow_page, shadow_col)];
    store_and_advance(use_xor ? (old ^ value) : (old | value));
  endfunction

  // apply one item to the shadow frame and build the result it should give
  function automatic out_item_t apply_text_op(in_item_t it);
    out_item_t res;
    logic [6:0] glyph;
    logic [39:0] bits;
    logic [7:0] colbyte;
    res = '0;
    case (it.opcode)
      OP_WRITE: store_and_advance(it.data_byte);
      OP_APPEND: combine_at_cursor(it.data_byte, it.invert_flag);
      OP_PIXEL: begin
        shadow_page = it.pixel_row[5:3];
        shadow_col = it.column;
        combine_at_cursor(8'd1 << it.pixel_row[2:0], it.invert_flag);
      end
      OP_CHAR: begin
        glyph = '0;
        if (it.char_code >= 7'(FIRST_CHAR) && it.char_code <= 7'(LAST_CHAR))
          glyph = it.char_code - 7'(FIRST_CHAR);
        else
          res.bad_char = 1'b1;
        bits = font[glyph];
        for (int i = 0; i < 5; i++) begin
          colbyte = bits[39 - 8*i -: 8];
          store_and_advance(it.invert_flag ? ~colbyte : colbyte);
        end
      end
      OP_GOTO: begin
        shadow_page = it.page;
        shadow_col = it.column;
      end
      OP_CLR_PG, OP_INV_PG: begin
        shadow_page = it.page;
        shadow_col = '0;
        for (int i = 0; i < NCOL; i++)
          store_and_advance(it.opcode == OP_INV_PG ?
                            ~shadow_frame[frame_index(shadow_page, shadow_col)] : 8'h00);
      end
      OP_READ: res.read_data = shadow_frame[frame_index(it.page, it.column)];
      OP_CLR_ALL: begin
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        shadow_page = '0;
        shadow_col = '0;
      end
      default: ;
    endcase
    res.cursor_page = shadow_page;
    res.cursor_column = shadow_col;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it = in_item_t'(36'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    // mostly text drawing and byte traffic, page ops rarely, odd opcodes seldom
    if (pick < 22) it.opcode = OP_CHAR;
    else if (pick < 36) it.opcode = OP_WRITE;
    else if (pick < 48) it.opcode = OP_APPEND;
    else if (pick < 60) it.opcode = OP_PIXEL;
    else if (pick < 70) it.opcode = OP_GOTO;
    else if (pick < 90) it.opcode = OP_READ;
    else if (pick < 93) it.opcode = OP_CLR_PG;
    else if (pick < 96) it.opcode = OP_INV_PG;
    else if (pick < 97) it.opcode = OP_CLR_ALL;
    else it.opcode = 4'($urandom_range(9, 15));
    if (it.opcode == OP_CHAR && $urandom_range(0, 9) != 0)
      it.char_code = 7'($urandom_range(FIRST_CHAR, LAST_CHAR));
    return it;
  endfunction

  function automatic in_item_t make_item(logic [3:0] op, logic [7:0] d, logic inv,
                                         logic [6:0] col, logic [5:0] row,
                                         logic [6:0] code, logic [2:0] pg);
    in_item_t it;
    it.opcode = op; it.data_byte = d; it.invert_flag = inv; it.column = col;
    it.pixel_row = row; it.char_code = code; it.page = pg;
    return it;
  endfunction

  // directed opening, then random traffic
  initial begin
    pending_items.push_back(make_item(OP_READ, 8'h00, 1'b0, 7'd127, 6'd0, 7'd0, 3'd7));
    pending_items.push_back(make_item(OP_WRITE, 8'hFF, 1'b0, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_WRITE, 8'h00, 1'b1, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_APPEND, 8'hA5, 1'b0, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_GOTO, 8'h00, 1'b0, 7'd2, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_APPEND, 8'hFF, 1'b1, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_PIXEL, 8'h00, 1'b0, 7'd127, 6'd63, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_PIXEL, 8'h00, 1'b1, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_GOTO, 8'h00, 1'b0, 7'd125, 6'd0, 7'd0, 3'd7));
    pending_items.push_back(make_item(OP_CHAR, 8'h00, 1'b0, 7'd0, 6'd0, 7'd65, 3'd0));
    pending_items.push_back(make_item(OP_CHAR, 8'h00, 1'b1, 7'd0, 6'd0, 7'd126, 3'd0));
    pending_items.push_back(make_item(OP_CHAR, 8'h00, 1'b0, 7'd0, 6'd0, 7'd32, 3'd0));
    pending_items.push_back(make_item(OP_CHAR, 8'h00, 1'b0, 7'd0, 6'd0, 7'd31, 3'd0));
    pending_items.push_back(make_item(OP_CHAR, 8'h00, 1'b1, 7'd0, 6'd0, 7'd127, 3'd0));
    pending_items.push_back(make_item(OP_CHAR, 8'h00, 1'b1, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_READ, 8'h00, 1'b0, 7'd1, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_INV_PG, 8'h00, 1'b0, 7'd0, 6'd0, 7'd0, 3'd7));
    pending_items.push_back(make_item(OP_READ, 8'h00, 1'b0, 7'd126, 6'd0, 7'd0, 3'd7));
    pending_items.push_back(make_item(OP_CLR_PG, 8'h00, 1'b0, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(4'd9, 8'h00, 1'b0, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(4'd15, 8'hFF, 1'b1, 7'd127, 6'd63, 7'd127, 3'd7));
    pending_items.push_back(make_item(OP_CLR_ALL, 8'h00, 1'b0, 7'd0, 6'd0, 7'd0, 3'd0));
    pending_items.push_back(make_item(OP_READ, 8'h00, 1'b0, 7'd127, 6'd0, 7'd0, 3'd7));
    for (int i = 0; i < 930; i++) pending_items.push_back(random_item());
  end

  // reset and the end of the run
  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    shadow_page = '0;
    shadow_col = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // sender: offers items from the queue, with idle bursts
  int in_gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_text_op(in_data));
        sent++;
      end
      if (in_valid && in_stall) begin
        // hold the offered item
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
      quiet_tail <= pending_items.size() < 120;
    end
  end

  // receiver: checks results, stalls in bursts, one long hold-off early on
  int out_gap = 0;
  bit long_done = 1'b0;
  out_item_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.cursor_page !== want.cursor_page)
            report_mismatch("cursor_page", out_data.cursor_page, want.cursor_page);
          if (out_data.cursor_column !== want.cursor_column)
            report_mismatch("cursor_column", out_data.cursor_column, want.cursor_column);
          if (out_data.bad_char !== want.bad_char)
            report_mismatch("bad_char", out_data.bad_char, want.bad_char);
        end
      end
      if (!long_done && sent == 60) begin
        long_done <= 1'b1;
        hold_off <= 200;
        out_stall <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no item accepted and no result taken
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
hw/rtl/pfbtw_pkg.sv
hw/rtl/pfbtw_ctrl.sv
hw/rtl/pfbtw_dp.sv
hw/rtl/paged_framebuffer_text_writer_core.sv
hw/rtl/pfbtw_checker.sv
dv/testbench.sv
